### rtl/mrrd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mrrd_pkg;

  localparam int unsigned DEF_BUFFER_DEPTH = 256;
  localparam int unsigned STORE_DEPTH      = 256;
  localparam int unsigned STORE_AW         = 8;
  localparam int unsigned LEN_W            = 9;
  localparam int unsigned LEFT_W           = 10;

  localparam logic [15:0] CRC_INIT        = 16'hFFFF;
  localparam logic [15:0] CRC_POLY        = 16'hA001;
  localparam logic [7:0]  DEFAULT_ADDRESS = 8'h01;

  // result event codes
  localparam logic [1:0] EVT_NONE    = 2'd0;
  localparam logic [1:0] EVT_FRAME   = 2'd1;
  localparam logic [1:0] EVT_CRC_ERR = 2'd2;
  localparam logic [1:0] EVT_RESYNC  = 2'd3;

  localparam logic KIND_LINE = 1'b0;
  localparam logic KIND_READ = 1'b1;

  // one byte through the reflected crc-16, bit by bit
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int b = 0; b < 8; b++) begin
      if (c[0]) c = (c >> 1) ^ CRC_POLY;
      else      c = c >> 1;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

### rtl/modbus_rtu_response_deframer.sv
`timescale 1ns / 1ps
`default_nettype none

// channel  | handshake            | payload
// ---------+----------------------+--------------------------------------------
// in       | in_valid / in_ready  | kind, rx_byte, read_index
// out      | out_valid/ out_ready | event_res, packet_ready, packet_length,
//          |                      | read_data
// cfg      | cfg_valid/ cfg_ready | cfg_data (expected_address)
//
// a store read passes through S_PRD and S_DONE; a line byte in the middle of a frame goes straight to S_DONE
// a frame end adds a crc pass over the frame bytes plus a copy pass into the packet store
// resync scans the buffer positions downward, plus a crc pass where address and count fit
// the crc, copy and resync steps run through the single read port of the receive buffer
// synchronous reset clears control state and the packet store valid bits
// a finished word waits in the output register; in_ready returns only after it is loaded
module modbus_rtu_response_deframer #(
  parameter int unsigned BUFFER_DEPTH = mrrd_pkg::DEF_BUFFER_DEPTH
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic                        kind,
  input  wire logic [7:0]                  rx_byte,
  input  wire logic [7:0]                  read_index,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [1:0]                       event_res,
  output logic                             packet_ready,
  output logic [mrrd_pkg::LEN_W-1:0]       packet_length,
  output logic [7:0]                       read_data,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [7:0]                  cfg_data
);
  import mrrd_pkg::*;

  localparam int unsigned AW = $clog2(BUFFER_DEPTH);
  localparam int unsigned CW = $clog2(BUFFER_DEPTH + 1);

  typedef enum logic [13:0] {
    S_IDLE  = 14'b00000000000001,
    S_PRD   = 14'b00000000000010,
    S_TAILH = 14'b00000000000100,
    S_TAILL = 14'b00000000001000,
    S_CSTRT = 14'b00000000010000,
    S_CRD   = 14'b00000000100000,
    S_CUPD  = 14'b00000001000000,
    S_CMP   = 14'b00000010000000,
    S_CPRD  = 14'b00000100000000,
    S_CPWR  = 14'b00001000000000,
    S_SRD1  = 14'b00010000000000,
    S_SRD2  = 14'b00100000000000,
    S_SCHK  = 14'b01000000000000,
    S_DONE  = 14'b10000000000000
  } state_t;

  state_t state;

  logic [7:0]              rbuf [BUFFER_DEPTH];
  logic [7:0]              rd_q;
  logic [7:0]              pstore [STORE_DEPTH];
  logic [STORE_DEPTH-1:0]  pvalid;
  logic [7:0]              pst_q;
  logic                    pvq;

  logic [7:0]              expected_address;
  logic [CW-1:0]           rc;
  logic signed [LEFT_W-1:0] bytes_left;
  logic                    resync;
  logic [LEN_W-1:0]        stored_length;
  logic                    ready_flag;

  logic [CW-1:0]           fstart;
  logic [CW-1:0]           fend;
  logic [CW-1:0]           ptr;
  logic [CW-1:0]           scan_i;
  logic [STORE_AW-1:0]     k;
  logic [7:0]              cnt;
  logic [7:0]              want_hi;
  logic [7:0]              want_lo;
  logic [15:0]             crc;
  logic [1:0]              evt;
  logic [7:0]              rdat;

  logic                    accept;
  logic [CW-1:0]           rcw;
  logic [CW-1:0]           rc_new;
  logic signed [LEFT_W-1:0] bl_next;
  logic [CW-1:0]           raddr_full;
  logic [AW-1:0]           raddr;
  logic [LEFT_W-1:0]       frame_sum;

  assign accept    = in_valid && in_ready;
  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  // write slot wraps at the buffer depth
  assign rcw    = (rc >= CW'(BUFFER_DEPTH)) ? '0 : rc;
  assign rc_new = rcw + CW'(1);

  // countdown rests at -1, reloads on the count byte
  always_comb begin
    bl_next = (bytes_left >= 0) ? bytes_left - LEFT_W'(1) : bytes_left;
    if (rcw == CW'(2)) bl_next = $signed({2'b00, rx_byte}) + LEFT_W'(2);
  end

  // read address of the receive buffer for each step
  always_comb begin
    unique case (state)
      S_TAILH:      raddr_full = fend - CW'(1);
      S_TAILL:      raddr_full = fend - CW'(2);
      S_CRD, S_CPRD: raddr_full = ptr;
      S_SRD1:       raddr_full = scan_i;
      S_SRD2:       raddr_full = scan_i - CW'(2);
      default:      raddr_full = '0;
    endcase
  end
  assign raddr = raddr_full[AW-1:0];

  // count byte at i must put the frame end exactly at the receive count
  assign frame_sum = LEFT_W'(cnt) + LEFT_W'(scan_i) + LEFT_W'(3);

  // receive buffer
  always_ff @(posedge clk) begin
    if (accept && kind == KIND_LINE) rbuf[rcw[AW-1:0]] <= rx_byte;
    rd_q <= rbuf[raddr];
  end

  // packet store
  always_ff @(posedge clk) begin
    if (state == S_CPWR) pstore[k] <= rd_q;
    pst_q <= pstore[read_index];
  end

  // control sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      pvalid           <= '0;
      pvq              <= 1'b0;
      expected_address <= DEFAULT_ADDRESS;
      rc               <= '0;
      bytes_left       <= '0;
      resync           <= 1'b0;
      stored_length    <= '0;
      ready_flag       <= 1'b1;
      out_valid        <= 1'b0;
      evt              <= EVT_NONE;
    end else begin
      if (cfg_valid) expected_address <= cfg_data;
      if (out_valid && out_ready && state != S_DONE) out_valid <= 1'b0;

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            rdat <= '0;
            if (kind == KIND_READ) begin
              pvq   <= pvalid[read_index];
              state <= S_PRD;
            end else begin
              ready_flag <= 1'b0;
              rc         <= rc_new;
              if (!resync) begin
                bytes_left <= bl_next;
                if (bl_next == 0) begin
                  if (rc_new < CW'(2)) begin
                    resync <= 1'b1;
                    evt    <= EVT_CRC_ERR;
                    state  <= S_DONE;
                  end else begin
                    fstart <= '0;
                    fend   <= rc_new;
                    state  <= S_TAILH;
                  end
                end else begin
                  state <= S_DONE;
                end
              end else if (rc_new >= CW'(3)) begin
                scan_i <= rc_new - CW'(1);
                state  <= S_SRD1;
              end else begin
                state <= S_DONE;
              end
            end
          end
        end
        S_PRD: begin
          rdat  <= pvq ? pst_q : 8'h00;
          state <= S_DONE;
        end
        S_TAILH: state <= S_TAILL;
        S_TAILL: begin
          want_hi <= rd_q;
          state   <= S_CSTRT;
        end
        S_CSTRT: begin
          want_lo <= rd_q;
          crc     <= CRC_INIT;
          ptr     <= fstart;
          state   <= (fstart == fend - CW'(2)) ? S_CMP : S_CRD;
        end
        S_CRD: state <= S_CUPD;
        S_CUPD: begin
          crc   <= crc16_byte(crc, rd_q);
          ptr   <= ptr + CW'(1);
          state <= (ptr + CW'(1) == fend - CW'(2)) ? S_CMP : S_CRD;
        end
        S_CMP: begin
          if (crc == {want_hi, want_lo}) begin
            ptr   <= fstart;
            k     <= '0;
            state <= S_CPRD;
          end else if (!resync) begin
            resync <= 1'b1;
            evt    <= EVT_CRC_ERR;
            state  <= S_DONE;
          end else if (scan_i == CW'(2)) begin
            state <= S_DONE;
          end else begin
            scan_i <= scan_i - CW'(1);
            state  <= S_SRD1;
          end
        end
        S_CPRD: state <= S_CPWR;
        S_CPWR: begin
          pvalid[k] <= 1'b1;
          k         <= k + STORE_AW'(1);
          ptr       <= ptr + CW'(1);
          if (ptr + CW'(1) == fend) begin
            stored_length <= LEN_W'(fend - fstart);
            rc            <= '0;
            ready_flag    <= 1'b1;
            evt           <= resync ? EVT_RESYNC : EVT_FRAME;
            resync        <= 1'b0;
            state         <= S_DONE;
          end else begin
            state <= S_CPRD;
          end
        end
        S_SRD1: state <= S_SRD2;
        S_SRD2: begin
          cnt   <= rd_q;
          state <= S_SCHK;
        end
        S_SCHK: begin
          if (frame_sum == LEFT_W'(rc) && rd_q == expected_address) begin
            fstart <= scan_i - CW'(2);
            fend   <= rc;
            state  <= S_TAILH;
          end else if (scan_i == CW'(2)) begin
            state <= S_DONE;
          end else begin
            scan_i <= scan_i - CW'(1);
            state  <= S_SRD1;
          end
        end
        S_DONE: begin
          // event is loaded into the output word on this edge, then cleared
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            evt       <= EVT_NONE;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (state == S_DONE && (!out_valid || out_ready)) begin
      event_res     <= evt;
      packet_ready  <= ready_flag;
      packet_length <= stored_length;
      read_data     <= rdat;
    end
  end

endmodule

`default_nettype wire

### rtl/mrrd_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module mrrd_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [1:0] event_res,
  input wire logic       packet_ready
);
  import mrrd_pkg::*;

  // a word held back by the sink stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(event_res))
    else $error("output word dropped or changed while stalled");

  // one word at a time: busy right after taking one
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while previous word in work");

  // a stored frame raises packet ready
  a_frame_ready: assert property (@(posedge clk) disable iff (rst)
    out_valid && (event_res == EVT_FRAME || event_res == EVT_RESYNC) |-> packet_ready)
    else $error("frame event without packet ready");

  // a crc error comes from a line word, so ready is low
  a_err_ready: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_res == EVT_CRC_ERR |-> !packet_ready)
    else $error("crc error with packet ready high");

  // idle and empty after reset
  a_reset: assert property (@(posedge clk)
    $past(rst) |-> in_ready && !out_valid)
    else $error("not idle after reset");

endmodule

bind modbus_rtu_response_deframer mrrd_checker u_mrrd_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .event_res    (event_res),
  .packet_ready (packet_ready)
);

`default_nettype wire
